// ----- hw/rtl/tabt_pkg.sv -----
// shared types and constants for the timed address block table
package tabt_pkg;

    localparam int unsigned TABLE_ENTRIES = 16;
    localparam int unsigned ADDR_W        = 64;
    localparam int unsigned SECS_W        = 22;
    localparam int unsigned TIME_W        = 31;
    localparam int unsigned SLOT_W        = 4;
    localparam int unsigned MS_W          = 10;
    localparam int unsigned PROD_W        = SECS_W + MS_W;

    localparam logic [MS_W-1:0]   MS_PER_SECOND = MS_W'(1000);
    localparam logic [TIME_W-1:0] TIME_MAX      = {TIME_W{1'b1}};

    localparam logic OP_BAN   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic              addr_type;
        logic [ADDR_W-1:0] addr_hi;
        logic [ADDR_W-1:0] addr_lo;
    } t_entry;

endpackage

// ----- hw/rtl/tabt_store.sv -----
// entry and expiry memories with per-entry valid bits
module tabt_store #(
    parameter int unsigned TABLE_ENTRIES = tabt_pkg::TABLE_ENTRIES,
    parameter int unsigned IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [IDX_W-1:0]              i_rd_idx,
    output tabt_pkg::t_entry              o_rd_entry,
    output logic [tabt_pkg::TIME_W-1:0]   o_rd_expiry,
    input  logic                          i_wr_en,
    input  logic [IDX_W-1:0]              i_wr_idx,
    input  tabt_pkg::t_entry              i_wr_entry,
    input  logic [tabt_pkg::TIME_W-1:0]   i_wr_expiry
);

    tabt_pkg::t_entry              mem_entry  [TABLE_ENTRIES];
    logic [tabt_pkg::TIME_W-1:0]   mem_expiry [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]      r_valid;

    tabt_pkg::t_entry              r_rd_entry;
    logic [tabt_pkg::TIME_W-1:0]   r_rd_expiry;
    logic                          r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_entry[i_wr_idx]  <= i_wr_entry;
            mem_expiry[i_wr_idx] <= i_wr_expiry;
        end
        if (i_rd_en) begin
            r_rd_entry  <= mem_entry[i_rd_idx];
            r_rd_expiry <= mem_expiry[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_idx];
            end
        end
    end

    // an entry never written reads as expired
    assign o_rd_entry  = r_rd_entry;
    assign o_rd_expiry = r_rd_valid ? r_rd_expiry : '0;

endmodule

// ----- hw/rtl/timed_address_block_table_unit.sv -----
// timed address block table: scan sequencer and result register
// a new word is accepted only in S_IDLE, once the previous one has finished; the scan is set by the
//   single read port of the table memory, one entry per cycle
// a held result stalls S_WRITE, and so also the next accept
// reset: synchronous active low; valid bits cleared at once, no clearing pass
module timed_address_block_table_unit #(
    parameter int unsigned TABLE_ENTRIES = tabt_pkg::TABLE_ENTRIES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_operation,
    input  logic                               i_addr_type,
    input  logic [tabt_pkg::ADDR_W-1:0]        i_addr_hi,
    input  logic [tabt_pkg::ADDR_W-1:0]        i_addr_lo,
    input  logic [tabt_pkg::SECS_W-1:0]        i_ban_seconds,
    input  logic [tabt_pkg::TIME_W-1:0]        i_now_ms,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_is_banned,
    output logic [tabt_pkg::SLOT_W-1:0]        o_slot_written,
    output logic                               o_evicted_live
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    tabt_pkg::t_state r_state, n_state;

    logic                              r_op;
    tabt_pkg::t_entry                  r_key;
    logic [tabt_pkg::TIME_W-1:0]       r_now;
    logic [tabt_pkg::PROD_W-1:0]       r_prod;
    logic [tabt_pkg::TIME_W-1:0]       r_expiry;

    logic [IDX_W-1:0]                  r_cnt;
    logic                              r_pend;
    logic [IDX_W-1:0]                  r_pidx;
    logic                              r_match;
    logic                              r_found;
    logic [IDX_W-1:0]                  r_slot;
    logic [IDX_W-1:0]                  r_old_idx;
    logic [tabt_pkg::TIME_W-1:0]       r_old_exp;

    logic                              r_out_valid;
    logic                              r_out_banned;
    logic [tabt_pkg::SLOT_W-1:0]       r_out_slot;
    logic                              r_out_evicted;

    logic                              accept;
    logic                              out_free;
    logic                              rd_en;
    logic                              finish;
    logic                              wr_en;
    logic [IDX_W-1:0]                  wr_idx;

    tabt_pkg::t_entry                  rd_entry;
    logic [tabt_pkg::TIME_W-1:0]       rd_expiry;
    logic                              rd_free;
    logic                              rd_live_hit;
    logic [tabt_pkg::PROD_W:0]         exp_sum;
    logic [tabt_pkg::TIME_W-1:0]       exp_sat;

    tabt_store #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (rd_en),
        .i_rd_idx    (r_cnt),
        .o_rd_entry  (rd_entry),
        .o_rd_expiry (rd_expiry),
        .i_wr_en     (wr_en),
        .i_wr_idx    (wr_idx),
        .i_wr_entry  (r_key),
        .i_wr_expiry (r_expiry)
    );

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign wr_idx   = r_found ? r_slot : r_old_idx;

    assign rd_free     = (rd_expiry == '0) || (rd_expiry < r_now);
    assign rd_live_hit = (rd_expiry != '0) && (rd_expiry > r_now) && (rd_entry == r_key);

    assign exp_sum = (tabt_pkg::PROD_W + 1)'(r_now) + (tabt_pkg::PROD_W + 1)'(r_prod);
    assign exp_sat = (exp_sum > (tabt_pkg::PROD_W + 1)'(tabt_pkg::TIME_MAX))
                   ? tabt_pkg::TIME_MAX : exp_sum[tabt_pkg::TIME_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tabt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = tabt_pkg::S_SCAN;
                end
            end
            tabt_pkg::S_SCAN: begin
                if (r_cnt == LAST_IDX) begin
                    n_state = tabt_pkg::S_LAST;
                end
            end
            tabt_pkg::S_LAST: begin
                n_state = tabt_pkg::S_WRITE;
            end
            tabt_pkg::S_WRITE: begin
                if (out_free) begin
                    n_state = tabt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tabt_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        finish     = 1'b0;
        case (r_state)
            tabt_pkg::S_IDLE:  o_in_ready = 1'b1;
            tabt_pkg::S_SCAN:  rd_en      = 1'b1;
            tabt_pkg::S_LAST:  rd_en      = 1'b0;
            tabt_pkg::S_WRITE: finish     = out_free;
            default:           o_in_ready = 1'b0;
        endcase
    end

    assign wr_en = finish && (r_op == tabt_pkg::OP_BAN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tabt_pkg::S_IDLE;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt <= '0;
            end else if (rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_pend <= rd_en;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item fields and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_operation;
            r_key     <= '{addr_type: i_addr_type, addr_hi: i_addr_hi, addr_lo: i_addr_lo};
            r_now     <= i_now_ms;
            r_prod    <= tabt_pkg::PROD_W'(i_ban_seconds) *
                         tabt_pkg::PROD_W'(tabt_pkg::MS_PER_SECOND);
            r_match   <= 1'b0;
            r_found   <= 1'b0;
            r_slot    <= '0;
            r_old_idx <= '0;
            r_old_exp <= '0;
        end else begin
            if (r_state == tabt_pkg::S_SCAN) begin
                r_expiry <= exp_sat;
            end
            if (r_pend) begin
                if (rd_live_hit) begin
                    r_match <= 1'b1;
                end
                if (!r_found) begin
                    if (rd_free) begin
                        r_found <= 1'b1;
                        r_slot  <= r_pidx;
                    end else if ((r_pidx == '0) || (rd_expiry < r_old_exp)) begin
                        r_old_idx <= r_pidx;
                        r_old_exp <= rd_expiry;
                    end
                end
            end
        end
        r_pidx <= r_cnt;
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (finish) begin
            if (r_op == tabt_pkg::OP_QUERY) begin
                r_out_banned  <= r_match;
                r_out_slot    <= '0;
                r_out_evicted <= 1'b0;
            end else begin
                r_out_banned  <= 1'b0;
                r_out_slot    <= tabt_pkg::SLOT_W'(wr_idx);
                r_out_evicted <= !r_found;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_banned    = r_out_banned;
    assign o_slot_written = r_out_slot;
    assign o_evicted_live = r_out_evicted;

`ifndef SYNTHESIS
    a_last_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tabt_pkg::S_LAST) |-> r_pend)
        else $error("final table entry not in flight");

    a_write_only_ban: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == tabt_pkg::S_WRITE) && (r_op == tabt_pkg::OP_BAN))
        else $error("table written outside a ban");

    a_query_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_banned) |-> (o_slot_written == '0) && !o_evicted_live)
        else $error("query word carries ban fields");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == tabt_pkg::S_SCAN) && (r_cnt == '0))
        else $error("scan did not start at entry zero");
`endif

endmodule
